### src/rms_pkg.sv
// Shared types, sizes and the string clean-up function for the record merge sorter.
package rms_pkg;

    localparam int DEPTH     = 64;
    localparam int STR_BYTES = 8;
    localparam int TEXT_W    = 64;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int IDX_W     = CNT_W + 2;

    typedef struct packed {
        logic [TEXT_W-1:0] name_text;
        logic [TEXT_W-1:0] number_text;
        logic              last_record;
    } t_in_item;

    typedef struct packed {
        logic [TEXT_W-1:0] sorted_name;
        logic [TEXT_W-1:0] sorted_number;
        logic              final_output;
        logic              overflow_seen;
    } t_out_item;

    typedef struct packed {
        logic [TEXT_W-1:0] name;
        logic [TEXT_W-1:0] number;
    } t_rec;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        t_rec              data;
    } t_ram_wr;

    typedef struct packed {
        logic             go;
        logic [CNT_W-1:0] n;
        logic             key_sel;
        logic             ovf;
    } t_seq_go;

    // Keep first STR_BYTES chars, zero everything from the first NUL on.
    function automatic logic [TEXT_W-1:0] clean_text(input logic [TEXT_W-1:0] v);
        logic [TEXT_W-1:0] r;
        logic              alive;
        logic [7:0]        ch;
        r     = '0;
        alive = 1'b1;
        for (int b = 0; b < 8; b++) begin
            ch = v[TEXT_W-1-8*b -: 8];
            if (b >= STR_BYTES || ch == 8'd0) begin
                alive = 1'b0;
            end
            if (alive) begin
                r[TEXT_W-1-8*b -: 8] = ch;
            end
        end
        return r;
    endfunction

endpackage

### src/record_merge_sorter.sv
// Record merge sorter top: load path, key select register, memories and merge sequencer.
// Load: one record per cycle while busy is low; a beat without last_record gives no result.
// Closing beat: ceil(log2 n) merge passes at run width w = 1, 2, 4.., each run pair set up, then a
// read state and a merge state per record (one shared compare, one write per merge), then n results.
// Each result has a read state then an emit state, final one marked; busy until the last result.
// Synchronous active-low reset empties the store and clears the key select to name order.
module record_merge_sorter
    import rms_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data,
    output logic      o_result_valid,
    output t_out_item o_result
);

    logic             r_sort_by_number;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;

    logic             accept, room;
    logic             seq_busy;
    t_seq_go          go;
    t_ram_wr          load_wr, seq_wr0, seq_wr1, wr0;
    logic [ADDR_W-1:0] raddr_a, raddr_b;
    t_rec             rd0_a, rd0_b, rd1_a, rd1_b;

    assign busy        = seq_busy;
    assign o_cfg_ready = ~seq_busy;
    assign accept      = start & ~seq_busy;
    assign room        = (r_count < CNT_W'(DEPTH));

    assign load_wr.en          = accept & room;
    assign load_wr.addr        = r_count[ADDR_W-1:0];
    assign load_wr.data.name   = clean_text(i_item.name_text);
    assign load_wr.data.number = clean_text(i_item.number_text);

    assign wr0 = seq_busy ? seq_wr0 : load_wr;

    always_comb begin
        n_count = r_count;
        n_ovf   = r_ovf;
        if (accept) begin
            if (room) begin
                n_count = r_count + 1'b1;
            end else begin
                n_ovf = 1'b1;
            end
        end
        go.go      = accept & i_item.last_record;
        go.n       = n_count;
        go.key_sel = r_sort_by_number;
        go.ovf     = n_ovf;
        if (go.go) begin
            n_count = '0;
            n_ovf   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sort_by_number <= 1'b0;
            r_count          <= '0;
            r_ovf            <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_sort_by_number <= i_cfg_data;
            end
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    rms_ram u_ram0 (
        .i_clk     (i_clk),
        .i_wr      (wr0),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd0_a),
        .o_rdata_b (rd0_b)
    );

    rms_ram u_ram1 (
        .i_clk     (i_clk),
        .i_wr      (seq_wr1),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rd1_a),
        .o_rdata_b (rd1_b)
    );

    rms_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_go           (go),
        .i_rd0_a        (rd0_a),
        .i_rd0_b        (rd0_b),
        .i_rd1_a        (rd1_a),
        .i_rd1_b        (rd1_b),
        .o_wr0          (seq_wr0),
        .o_wr1          (seq_wr1),
        .o_raddr_a      (raddr_a),
        .o_raddr_b      (raddr_b),
        .o_busy         (seq_busy),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

### src/rms_ram.sv
// Record memory: one write port, two registered read ports.
module rms_ram
    import rms_pkg::*;
(
    input  logic              i_clk,
    input  t_ram_wr           i_wr,
    input  logic [ADDR_W-1:0] i_raddr_a,
    input  logic [ADDR_W-1:0] i_raddr_b,
    output t_rec              o_rdata_a,
    output t_rec              o_rdata_b
);

    t_rec mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

### src/rms_seq.sv
// Merge sequencer: bottom-up merge passes ping-ponging between two memories, then emit.
module rms_seq
    import rms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_seq_go           i_go,
    input  t_rec              i_rd0_a,
    input  t_rec              i_rd0_b,
    input  t_rec              i_rd1_a,
    input  t_rec              i_rd1_b,
    output t_ram_wr           o_wr0,
    output t_ram_wr           o_wr1,
    output logic [ADDR_W-1:0] o_raddr_a,
    output logic [ADDR_W-1:0] o_raddr_b,
    output logic              o_busy,
    output logic              o_result_valid,
    output t_out_item         o_result
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PASS  = 3'd1;
    localparam logic [2:0] S_SETUP = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_MERGE = 3'd4;
    localparam logic [2:0] S_ORD   = 3'd5;
    localparam logic [2:0] S_OEMIT = 3'd6;

    logic [2:0]       r_state, n_state;
    logic [IDX_W-1:0] r_n, n_n;
    logic [IDX_W-1:0] r_width, n_width;
    logic [IDX_W-1:0] r_lo, n_lo;
    logic [IDX_W-1:0] r_mid, n_mid;
    logic [IDX_W-1:0] r_hi, n_hi;
    logic [IDX_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_j, n_j;
    logic [IDX_W-1:0] r_k, n_k;
    logic             r_src, n_src;
    logic             r_key, n_key;
    logic             r_ovf, n_ovf;

    t_rec             left_rec, right_rec, out_rec;
    logic [TEXT_W-1:0] key_l, key_r;
    logic             take_left;
    logic [IDX_W-1:0] sum_mid, sum_hi;
    t_ram_wr          wr;

    assign left_rec  = r_src ? i_rd1_a : i_rd0_a;
    assign right_rec = r_src ? i_rd1_b : i_rd0_b;
    assign key_l     = r_key ? left_rec.number  : left_rec.name;
    assign key_r     = r_key ? right_rec.number : right_rec.name;
    assign sum_mid   = r_lo + r_width;
    assign sum_hi    = r_lo + (r_width << 1);

    always_comb begin
        if (r_i >= r_mid) begin
            take_left = 1'b0;
        end else if (r_j >= r_hi) begin
            take_left = 1'b1;
        end else begin
            take_left = (key_l <= key_r);
        end
    end

    assign out_rec   = take_left ? left_rec : right_rec;
    assign wr.en     = (r_state == S_MERGE);
    assign wr.addr   = r_k[ADDR_W-1:0];
    assign wr.data   = out_rec;

    always_comb begin
        o_wr0    = wr;
        o_wr1    = wr;
        o_wr0.en = wr.en & r_src;
        o_wr1.en = wr.en & ~r_src;
    end

    assign o_raddr_a = (r_state == S_ORD) ? r_k[ADDR_W-1:0] : r_i[ADDR_W-1:0];
    assign o_raddr_b = r_j[ADDR_W-1:0];
    assign o_busy    = (r_state != S_IDLE);

    assign o_result_valid          = (r_state == S_OEMIT);
    assign o_result.sorted_name    = left_rec.name;
    assign o_result.sorted_number  = left_rec.number;
    assign o_result.final_output   = (r_k + 1'b1 == r_n);
    assign o_result.overflow_seen  = r_ovf;

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_width = r_width;
        n_lo    = r_lo;
        n_mid   = r_mid;
        n_hi    = r_hi;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_src   = r_src;
        n_key   = r_key;
        n_ovf   = r_ovf;
        case (r_state)
            S_IDLE: begin
                if (i_go.go) begin
                    n_n     = IDX_W'(i_go.n);
                    n_key   = i_go.key_sel;
                    n_ovf   = i_go.ovf;
                    n_width = IDX_W'(1);
                    n_src   = 1'b0;
                    n_state = S_PASS;
                end
            end
            S_PASS: begin
                if (r_width >= r_n) begin
                    n_k     = '0;
                    n_state = S_ORD;
                end else begin
                    n_lo    = '0;
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_mid   = (sum_mid > r_n) ? r_n : sum_mid;
                n_hi    = (sum_hi > r_n) ? r_n : sum_hi;
                n_i     = r_lo;
                n_j     = (sum_mid > r_n) ? r_n : sum_mid;
                n_k     = r_lo;
                n_state = S_READ;
            end
            S_READ: begin
                n_state = S_MERGE;
            end
            S_MERGE: begin
                if (take_left) begin
                    n_i = r_i + 1'b1;
                end else begin
                    n_j = r_j + 1'b1;
                end
                n_k = r_k + 1'b1;
                if (r_k + 1'b1 == r_hi) begin
                    if (r_hi >= r_n) begin
                        n_width = r_width << 1;
                        n_src   = ~r_src;
                        n_state = S_PASS;
                    end else begin
                        n_lo    = r_hi;
                        n_state = S_SETUP;
                    end
                end else begin
                    n_state = S_READ;
                end
            end
            S_ORD: begin
                n_state = S_OEMIT;
            end
            S_OEMIT: begin
                n_k = r_k + 1'b1;
                if (r_k + 1'b1 == r_n) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_ORD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_n     <= n_n;
        r_width <= n_width;
        r_lo    <= n_lo;
        r_mid   <= n_mid;
        r_hi    <= n_hi;
        r_i     <= n_i;
        r_j     <= n_j;
        r_k     <= n_k;
        r_src   <= n_src;
        r_key   <= n_key;
        r_ovf   <= n_ovf;
    end

endmodule

### dv/tb_top.sv
// Self-checking testbench for the record merge sorter: set loads, stable sort checks, both keys.
`timescale 1ns / 100ps

module tb_top;
    import rms_pkg::*;

    localparam int DRAIN_LIMIT = 200000;
    localparam int SETTLE      = 40;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      start       = 1'b0;
    t_in_item  i_item      = '0;
    logic      i_cfg_valid = 1'b0;
    logic      i_cfg_data  = 1'b0;
    logic      busy;
    logic      o_cfg_ready;
    logic      o_result_valid;
    t_out_item o_result;

    t_in_item  pend_q[$];
    t_out_item sorted_q[$];
    t_rec      rec_store[DEPTH];
    int        rec_cnt       = 0;
    logic      drop_seen     = 1'b0;
    logic      key_by_number = 1'b0;
    int        gap_pct       = 0;
    int        err_cnt       = 0;

    record_merge_sorter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [TEXT_W-1:0] trim_text(input logic [TEXT_W-1:0] v);
        logic [TEXT_W-1:0] r;
        logic              live;
        r    = '0;
        live = 1'b1;
        for (int b = 0; b < 8; b++) begin
            if (b >= STR_BYTES || v[TEXT_W-1-8*b -: 8] == 8'd0) begin
                live = 1'b0;
            end
            if (live) begin
                r[TEXT_W-1-8*b -: 8] = v[TEXT_W-1-8*b -: 8];
            end
        end
        return r;
    endfunction

    function automatic logic [TEXT_W-1:0] sort_key(input t_rec r);
        return key_by_number ? r.number : r.name;
    endfunction

    // Load one record into the shadow store; a closing beat sorts and queues the set.
    function automatic void absorb_record(input t_in_item it);
        t_rec      cur;
        t_out_item res;
        int        j;
        if (rec_cnt < DEPTH) begin
            rec_store[rec_cnt].name   = trim_text(it.name_text);
            rec_store[rec_cnt].number = trim_text(it.number_text);
            rec_cnt++;
        end else begin
            drop_seen = 1'b1;
        end
        if (it.last_record) begin
            for (int i = 1; i < rec_cnt; i++) begin
                cur = rec_store[i];
                j   = i;
                while (j > 0 && sort_key(rec_store[j-1]) > sort_key(cur)) begin
                    rec_store[j] = rec_store[j-1];
                    j--;
                end
                rec_store[j] = cur;
            end
            for (int k = 0; k < rec_cnt; k++) begin
                res.sorted_name   = rec_store[k].name;
                res.sorted_number = rec_store[k].number;
                res.final_output  = (k == rec_cnt - 1);
                res.overflow_seen = drop_seen;
                sorted_q.push_back(res);
            end
            rec_cnt   = 0;
            drop_seen = 1'b0;
        end
    endfunction

    always @(posedge i_clk) begin : drv
        logic nstart;
        if (!i_rst_n) begin
            start  <= 1'b0;
            i_item <= '0;
        end else begin
            nstart = start;
            if (start && !busy) begin
                absorb_record(i_item);
                nstart = 1'b0;
            end
            if (!nstart && pend_q.size() > 0 && $urandom_range(99) >= gap_pct) begin
                i_item <= pend_q.pop_front();
                nstart = 1'b1;
            end
            start <= nstart;
        end
    end

    function automatic void cmp_field(input string nm, input logic [TEXT_W-1:0] want,
                                      input logic [TEXT_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch expected %h actual %h", $time, nm, want, got);
            err_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin : mon
        t_out_item want;
        if (i_rst_n && o_result_valid) begin
            if (sorted_q.size() == 0) begin
                $display("%0t: unexpected result expected none actual %h", $time, o_result);
                err_cnt++;
            end else begin
                want = sorted_q.pop_front();
                cmp_field("sorted_name", want.sorted_name, o_result.sorted_name);
                cmp_field("sorted_number", want.sorted_number, o_result.sorted_number);
                cmp_field("final_output", 64'(want.final_output), 64'(o_result.final_output));
                cmp_field("overflow_seen", 64'(want.overflow_seen), 64'(o_result.overflow_seen));
            end
        end
    end

    function automatic logic [TEXT_W-1:0] tie_text(input int idx);
        case (idx)
            0:       return 64'h4142_0000_0000_0000;
            1:       return 64'h4142_00FF_1234_5678;
            2:       return 64'h4142_4300_0000_0000;
            default: return 64'h8000_0000_0000_0000;
        endcase
    endfunction

    function automatic logic [TEXT_W-1:0] rand_text();
        logic [TEXT_W-1:0] v;
        int                len;
        v = '0;
        case ($urandom_range(3))
            0: v = {$urandom, $urandom};
            1: begin
                len = $urandom_range(8);
                for (int b = 0; b < 8; b++) begin
                    if (b < len) begin
                        v[63-8*b -: 8] = 8'($urandom_range(255, 1));
                    end else if ($urandom_range(3) == 0) begin
                        v[63-8*b -: 8] = 8'($urandom);
                    end
                end
            end
            2: v = tie_text($urandom_range(3));
            default: begin
                v       = tie_text($urandom_range(3));
                v[31:0] = $urandom;
            end
        endcase
        return v;
    endfunction

    task automatic push_rec(input logic [TEXT_W-1:0] nm, input logic [TEXT_W-1:0] num,
                            input logic last);
        t_in_item it;
        it.name_text   = nm;
        it.number_text = num;
        it.last_record = last;
        pend_q.push_back(it);
    endtask

    task automatic add_set(input int n);
        for (int k = 1; k <= n; k++) begin
            push_rec(rand_text(), rand_text(), k == n);
        end
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while ((pend_q.size() != 0 || start || sorted_q.size() != 0) && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (guard >= DRAIN_LIMIT) begin
            $display("%0t: results outstanding expected 0 actual %0d", $time, sorted_q.size());
            err_cnt++;
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_sort_key(input logic v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid   <= 1'b0;
        key_by_number = v;
    endtask

    initial begin : main
        int pct[4];
        int cnt;
        int n;
        pct = '{0, 48, 0, 19};
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // name order at reset value: single record, then extremes and ties
        @(negedge i_clk);
        push_rec(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b1);
        push_rec(64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        push_rec(64'hFFFF_FFFF_FFFF_FFFF, 64'h6162_0000_0000_0000, 1'b0);
        push_rec(64'h4142_00FF_1234_5678, 64'h3100_0000_0000_0000, 1'b0);
        push_rec(64'h4142_0000_0000_0000, 64'h3200_0000_0000_0000, 1'b0);
        push_rec(64'h8000_0000_0000_0000, 64'h00FF_FFFF_FFFF_FFFF, 1'b0);
        push_rec(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001, 1'b1);
        drain();

        write_sort_key(1'b1);
        @(negedge i_clk);
        push_rec(64'h0000_0000_0000_0001, 64'h3130_0000_0000_0000, 1'b0);
        push_rec(64'hAAAA_AAAA_AAAA_AAAA, 64'h3130_00AA_5555_0000, 1'b0);
        push_rec(64'h5555_5555_5555_5555, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        push_rec(64'h6100_0000_0000_0000, 64'h0, 1'b0);
        push_rec(64'h6200_0000_0000_0000, 64'h7F00_0000_0000_0000, 1'b0);
        push_rec(64'h6300_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b1);
        drain();

        for (int p = 0; p < 4; p++) begin
            write_sort_key(p[0]);
            gap_pct = pct[p];
            @(negedge i_clk);
            if (p == 0) add_set(DEPTH);
            if (p == 1) add_set(DEPTH + 3);
            cnt = 0;
            while (cnt < 6) begin
                n = $urandom_range(8, 1);
                add_set(n);
                cnt += n;
            end
            drain();
        end

        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
